### hw/rtl/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

	// Receive window geometry
	localparam int WINDOW_DEPTH = 64;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	// Frame format
	localparam logic [7:0] HDR_BYTE = 8'hFF;
	localparam int MIN_LEN     = 2;
	localparam int MAX_LEN     = 32;
	localparam int HDR_OVH     = 4;          // header, id, length bytes ahead of the length span
	localparam int MIN_SCAN    = 6;          // bytes held before a scan starts
	localparam int STATUS_LEN  = 4;          // shortest length that carries data
	localparam int TOT_W       = $clog2(MAX_LEN + HDR_OVH + 1);

	// Byte positions inside a frame
	localparam int POS_HDR1 = 1;
	localparam int POS_ID   = 2;
	localparam int POS_LEN  = 3;
	localparam int POS_ERR  = 4;
	localparam int POS_DATA = 5;

	// Results per received byte
	localparam int MAX_RESULTS = 8;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_RESEND = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		WIN_NOP,
		WIN_CLEAR,
		WIN_PUSH,
		WIN_DROP
	} win_op_t;

	typedef struct packed {
		win_op_t          op;
		logic [CNT_W-1:0] amount;
		logic [IDX_W-1:0] rd_off;
		logic [7:0]       wdata;
	} win_cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  id;
		logic [7:0]  err;
		logic [7:0]  accum;
		logic [31:0] raw;
		logic        last;
	} result_t;

	typedef struct packed {
		logic             idle;
		logic             pend_valid;
		logic             done;
		logic [CNT_W-1:0] count;
	} ctrl_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_H0,
		ST_H1,
		ST_LEN,
		ST_SUM,
		ST_EMIT,
		ST_END
	} state_t;

endpackage

### hw/rtl/ssp_window.sv
`timescale 1ns / 1ps

module ssp_window import ssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  win_cmd_t         cmd,
	output logic [7:0]       rd_data,
	output logic [CNT_W-1:0] count
);

	logic [7:0]       mem [WINDOW_DEPTH];
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic [IDX_W-1:0] wr_addr;

	// head plus offset, folded back into the ring (offset below depth)
	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
	                                          input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(WINDOW_DEPTH))
			s = s - (IDX_W+1)'(WINDOW_DEPTH);
		return s[IDX_W-1:0];
	endfunction

	assign full    = (count_q == CNT_W'(WINDOW_DEPTH));
	assign wr_addr = full ? head_q : wrap(head_q, count_q[IDX_W-1:0]);
	assign count   = count_q;

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				WIN_CLEAR: count_q <= '0;
				WIN_PUSH: begin
					if (full)
						head_q <= wrap(head_q, IDX_W'(1));
					else
						count_q <= count_q + CNT_W'(1);
				end
				WIN_DROP: begin
					head_q <= wrap(head_q, cmd.amount[IDX_W-1:0]);
					if (cmd.amount >= count_q)
						count_q <= '0;
					else
						count_q <= count_q - cmd.amount;
				end
				default: ;
			endcase
		end
	end

	// byte store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.op == WIN_PUSH)
			mem[wr_addr] <= cmd.wdata;
		rd_data <= mem[wrap(head_q, cmd.rd_off)];
	end

endmodule

### hw/rtl/ssp_ctrl.sv
`timescale 1ns / 1ps

module ssp_ctrl import ssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	input  logic [7:0]       in_byte,
	output logic             in_ready,
	input  logic             out_free,
	output logic             out_push,
	output result_t          out_res,
	output win_cmd_t         win_cmd,
	input  logic [7:0]       win_rd,
	input  logic [CNT_W-1:0] win_count,
	output ctrl_stat_t       stat
);

	state_t           state_q, state_d;
	logic [RES_W-1:0] n_q, n_d;
	logic [7:0]       len_q, len_d;
	logic [TOT_W-1:0] total_q, total_d;
	logic [TOT_W-1:0] cur_q, cur_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       id_q, id_d;
	logic [7:0]       err_q, err_d;
	logic [31:0]      raw_q, raw_d;
	logic [7:0]       sticky_q, sticky_d;
	logic             done_q, done_d;
	result_t          new_q, new_d;
	result_t          pend_q, pend_d;
	logic             pend_valid_q, pend_valid_d;

	logic [TOT_W-1:0] last_idx;
	logic [TOT_W-1:0] len_total;
	logic [31:0]      raw_full;
	logic [7:0]       sticky_or;

	assign last_idx  = total_q - TOT_W'(1);
	assign len_total = TOT_W'(win_rd) + TOT_W'(HDR_OVH);
	assign sticky_or = sticky_q | err_q;

	assign stat.idle       = (state_q == ST_IDLE);
	assign stat.pend_valid = pend_valid_q;
	assign stat.done       = done_q;
	assign stat.count      = win_count;

	// payload bytes folded into the value as they stream past
	always_comb begin
		raw_full = raw_q;
		if (cur_q == TOT_W'(POS_DATA))
			raw_full[7:0] = win_rd;
		else if (cur_q == TOT_W'(POS_DATA + 1))
			raw_full[15:8] = win_rd;
		else if (cur_q == TOT_W'(POS_DATA + 2))
			raw_full[23:16] = win_rd;
		else if (cur_q == TOT_W'(POS_DATA + 3))
			raw_full[31:24] = win_rd;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			sticky_q     <= '0;
			done_q       <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			n_q          <= n_d;
			sticky_q     <= sticky_d;
			done_q       <= done_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		len_q   <= len_d;
		total_q <= total_d;
		cur_q   <= cur_d;
		sum_q   <= sum_d;
		id_q    <= id_d;
		err_q   <= err_d;
		raw_q   <= raw_d;
		new_q   <= new_d;
		pend_q  <= pend_d;
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		n_d          = n_q;
		len_d        = len_q;
		total_d      = total_q;
		cur_d        = cur_q;
		sum_d        = sum_q;
		id_d         = id_q;
		err_d        = err_q;
		raw_d        = raw_q;
		sticky_d     = sticky_q;
		done_d       = done_q;
		new_d        = new_q;
		pend_d       = pend_q;
		pend_valid_d = pend_valid_q;
		in_ready     = 1'b0;
		out_push     = 1'b0;
		out_res      = pend_q;
		win_cmd.op     = WIN_NOP;
		win_cmd.amount = '0;
		win_cmd.rd_off = '0;
		win_cmd.wdata  = in_byte;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action) begin
						win_cmd.op = WIN_CLEAR;
						sticky_d   = '0;
						done_d     = 1'b0;
					end else if (!done_q) begin
						win_cmd.op = WIN_PUSH;
						n_d        = '0;
						state_d    = ST_CHK;
					end
				end
			end

			ST_CHK: begin
				if (win_count >= CNT_W'(MIN_SCAN) && !done_q &&
				    n_q < RES_W'(MAX_RESULTS)) begin
					win_cmd.rd_off = '0;
					state_d        = ST_H0;
				end else begin
					state_d = ST_END;
				end
			end

			ST_H0: begin
				if (win_rd != HDR_BYTE) begin
					win_cmd.op     = WIN_DROP;
					win_cmd.amount = CNT_W'(1);
					state_d        = ST_CHK;
				end else begin
					win_cmd.rd_off = IDX_W'(POS_HDR1);
					state_d        = ST_H1;
				end
			end

			ST_H1: begin
				if (win_rd != HDR_BYTE) begin
					win_cmd.op     = WIN_DROP;
					win_cmd.amount = CNT_W'(1);
					state_d        = ST_CHK;
				end else begin
					win_cmd.rd_off = IDX_W'(POS_LEN);
					state_d        = ST_LEN;
				end
			end

			ST_LEN: begin
				if (win_rd < 8'(MIN_LEN) || win_rd > 8'(MAX_LEN)) begin
					// bad length: flush and ask for a resend
					win_cmd.op  = WIN_CLEAR;
					new_d       = '0;
					new_d.kind  = KIND_RESEND;
					new_d.accum = sticky_q;
					state_d     = ST_EMIT;
				end else if (win_count < CNT_W'(len_total)) begin
					state_d = ST_END;
				end else begin
					len_d          = win_rd;
					total_d        = len_total;
					cur_d          = TOT_W'(POS_ID);
					sum_d          = '0;
					raw_d          = '0;
					win_cmd.rd_off = IDX_W'(POS_ID);
					state_d        = ST_SUM;
				end
			end

			ST_SUM: begin
				raw_d = raw_full;
				if (cur_q == TOT_W'(POS_ID))
					id_d = win_rd;
				if (cur_q == TOT_W'(POS_ERR))
					err_d = win_rd;
				if (cur_q != last_idx) begin
					// shared adder: running byte sum
					sum_d          = sum_q + win_rd;
					cur_d          = cur_q + TOT_W'(1);
					win_cmd.rd_off = IDX_W'(cur_q + TOT_W'(1));
				end else if (~sum_q != win_rd) begin
					// checksum failure
					win_cmd.op     = WIN_DROP;
					win_cmd.amount = CNT_W'(1);
					if (len_q > 8'(STATUS_LEN)) begin
						win_cmd.op  = WIN_CLEAR;
						new_d       = '0;
						new_d.kind  = KIND_RESEND;
						new_d.accum = sticky_q;
						state_d     = ST_EMIT;
					end else begin
						state_d = ST_CHK;
					end
				end else begin
					// good frame
					win_cmd.op     = WIN_DROP;
					win_cmd.amount = CNT_W'(total_q);
					sticky_d       = sticky_or;
					new_d.id       = id_q;
					new_d.err      = err_q;
					new_d.accum    = sticky_or;
					new_d.last     = 1'b0;
					if (len_q < 8'(STATUS_LEN)) begin
						new_d.kind = KIND_STATUS;
						new_d.raw  = '0;
					end else begin
						new_d.kind = KIND_DATA;
						new_d.raw  = raw_full;
						done_d     = 1'b1;
					end
					state_d = ST_EMIT;
				end
			end

			ST_EMIT: begin
				// hold one result back until the next one shows whether it ends the run
				if (!pend_valid_q) begin
					pend_d       = new_q;
					pend_valid_d = 1'b1;
					n_d          = n_q + RES_W'(1);
					state_d      = ST_CHK;
				end else if (out_free) begin
					out_push     = 1'b1;
					out_res.last = 1'b0;
					pend_d       = new_q;
					n_d          = n_q + RES_W'(1);
					state_d      = ST_CHK;
				end
			end

			ST_END: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_push     = 1'b1;
					out_res.last = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/servo_status_packet_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                               tuser    tlast
// s_*       in         rx_byte[7:0]                                     action   -
// m_*       out        frame_id, frame_error, error_accum, raw_word,   kind     last
//                      position_raw, speed_signed
//
// The window memory has a single read port, which delivers one byte per cycle to the
// shared sum adder.
// Reset clears the ring pointers, counters and flags; the window memory is not cleared.
// A full output register stalls the sequencer in its emit steps; input waits meanwhile.

module servo_status_packet_parser import ssp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // frame_id, frame_error, error_accum, raw_word,
	                               // position_raw, speed_signed
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	win_cmd_t         win_cmd;
	logic [7:0]       win_rd;
	logic [CNT_W-1:0] win_count;
	ctrl_stat_t       stat;
	logic             out_free;
	logic             out_push;
	result_t          out_res;
	logic             m_valid_q;
	result_t          m_res_q;
	logic [15:0]      upper;
	logic [15:0]      mag;
	logic signed [15:0] speed;

	ssp_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (win_cmd),
		.rd_data (win_rd),
		.count   (win_count)
	);

	ssp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.out_push  (out_push),
		.out_res   (out_res),
		.win_cmd   (win_cmd),
		.win_rd    (win_rd),
		.win_count (win_count),
		.stat      (stat)
	);

	assign out_free = !m_valid_q || m_tready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push)
			m_res_q <= out_res;
	end

	// sign-magnitude upper half to two's complement
	assign upper = m_res_q.raw[31:16];
	assign mag   = {1'b0, upper[14:0]};
	assign speed = upper[15] ? -$signed(mag) : $signed(mag);

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.kind;
	assign m_tlast  = m_res_q.last;
	assign m_tdata  = {speed, m_res_q.raw[15:0], m_res_q.raw, m_res_q.accum,
	                   m_res_q.err, m_res_q.id};

	// no held-back result survives into idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle |-> !stat.pend_valid)
		else $error("result still held back while idle");

	// a data frame or resend always closes the run of results
	a_final_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DATA || m_tuser == KIND_RESEND) |-> m_tlast)
		else $error("data or resend result not marked last");

	// sequencer only loads the output register when it is free
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (!m_valid_q || m_tready))
		else $error("output register overwritten");

	// window never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(WINDOW_DEPTH))
		else $error("window count out of range");

	// done blocks any further scan result until a new request
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && $past(stat.done) && stat.idle |-> !stat.pend_valid)
		else $error("activity after data frame");

endmodule

### bench/tb_servo_status_packet_parser.sv
`timescale 1ns / 1ps

module tb_servo_status_packet_parser;
	import ssp_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int DRAIN_CYCLES  = 200;
	localparam int RANDOM_ITEMS  = 310;
	localparam int PHASE_COUNT   = 4;
	localparam int HOLD_CYCLES   = 400;

	// One status result as it leaves the parser
	typedef struct {
		kind_t       kind;
		logic [7:0]  id;
		logic [7:0]  err;
		logic [7:0]  accum;
		logic [31:0] raw;
		logic [15:0] pos;
		logic [15:0] spd;
		logic        last;
	} frame_result_t;

	// Directed row: byte or request, with an optional hand-typed result
	typedef struct {
		logic       act;
		logic [7:0] data;
		bit         typed;
		kind_t      kind;
		logic [7:0] id;
		logic [7:0] err;
		logic [7:0] accum;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	servo_status_packet_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Parser state as the bench sees it
	logic [7:0]    held_bytes[$];
	logic [7:0]    sticky_err = '0;
	bit            halted = 1'b0;
	frame_result_t step_results[$];
	frame_result_t pending_results[$];
	frame_result_t hand_res;

	int errors = 0;
	int items_sent = 0;
	int directed_items = 0;
	int predicted = 0;
	int results_seen = 0;
	int kind_seen[3] = '{0, 0, 0};
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	// Directed frames: oversize length, status-only, short data frame, byte while done
	stim_row_t stim_rows[23] = '{
		'{1'b1, 8'h00, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h00, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h21, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h00, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h00, 1'b1, KIND_RESEND, 8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h01, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h02, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h80, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h7C, 1'b1, KIND_STATUS, 8'h01, 8'h80, 8'h80},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFE, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h04, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h01, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h00, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h80, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h7C, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h55, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00},
		'{1'b1, 8'hFF, 1'b0, KIND_DATA,   8'h00, 8'h00, 8'h00}
	};

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Build one result; speed is sign-magnitude in the upper half
	function automatic frame_result_t make_result(input kind_t kind, input logic [7:0] id,
			input logic [7:0] err, input logic [31:0] raw);
		frame_result_t r;
		logic [15:0] upper;
		logic [15:0] mag;
		upper = raw[31:16];
		mag = {1'b0, upper[14:0]};
		r.kind = kind;
		r.id = id;
		r.err = err;
		r.accum = sticky_err;
		r.raw = raw;
		r.pos = raw[15:0];
		r.spd = upper[15] ? (16'h0000 - mag) : mag;
		r.last = 1'b0;
		return r;
	endfunction

	// Push one byte or request through the frame scanner
	function automatic void parse_rx_byte(input logic act, input logic [7:0] b);
		int n;
		int len;
		int total;
		logic [7:0] sum;
		logic [7:0] id;
		logic [7:0] err;
		logic [31:0] raw;
		bit stop;
		step_results.delete();
		if (act) begin
			held_bytes.delete();
			sticky_err = '0;
			halted = 1'b0;
			return;
		end
		if (halted)
			return;
		if (held_bytes.size() >= WINDOW_DEPTH)
			void'(held_bytes.pop_front());
		held_bytes = {held_bytes, b};
		n = 0;
		stop = 1'b0;
		while (!stop && held_bytes.size() >= MIN_SCAN && !halted && n < MAX_RESULTS) begin
			if (held_bytes[0] != HDR_BYTE || held_bytes[POS_HDR1] != HDR_BYTE) begin
				// resync: slide until the header lines up
				void'(held_bytes.pop_front());
			end else begin
				len = held_bytes[POS_LEN];
				if (len < MIN_LEN || len > MAX_LEN) begin
					held_bytes.delete();
					step_results = {step_results, make_result(KIND_RESEND, '0, '0, '0)};
					n++;
					stop = 1'b1;
				end else begin
					total = HDR_OVH + len;
					if (held_bytes.size() < total) begin
						stop = 1'b1;
					end else begin
						sum = '0;
						for (int i = POS_ID; i < total - 1; i++)
							sum += held_bytes[i];
						if (~sum != held_bytes[total - 1]) begin
							// bad checksum: long frames ask for a resend
							void'(held_bytes.pop_front());
							if (len > STATUS_LEN) begin
								held_bytes.delete();
								step_results = {step_results,
									make_result(KIND_RESEND, '0, '0, '0)};
								n++;
								stop = 1'b1;
							end
						end else begin
							id = held_bytes[POS_ID];
							err = held_bytes[POS_ERR];
							sticky_err |= err;
							raw = '0;
							for (int i = 0; i < 4; i++)
								if (POS_DATA + i < total)
									raw |= 32'(held_bytes[POS_DATA + i]) << (8 * i);
							repeat (total) void'(held_bytes.pop_front());
							if (len < STATUS_LEN) begin
								step_results = {step_results,
									make_result(KIND_STATUS, id, err, '0)};
							end else begin
								halted = 1'b1;
								step_results = {step_results,
									make_result(KIND_DATA, id, err, raw)};
							end
							n++;
						end
					end
				end
			end
		end
		if (n > 0)
			step_results[n - 1].last = 1'b1;
	endfunction

	// Offer one input transfer; called and returns at a falling edge
	task automatic send_item(input logic act, input logic [7:0] b, input bit by_hand = 1'b0);
		bit ignored;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		ignored = !act && halted;
		parse_rx_byte(act, b);
		if (by_hand) begin
			pending_results = {pending_results, hand_res};
			predicted++;
		end else begin
			pending_results = {pending_results, step_results};
			predicted += step_results.size();
		end
		if (!ignored)
			items_sent++;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Stop offering and let every expected result drain
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_phase(input int idle, input int stall, input int hold);
		@(posedge clk);
		idle_pct = idle;
		stall_pct = stall;
		hold_req = hold;
		@(negedge clk);
	endtask

	// One random frame: mostly well-formed, some noise, bad lengths, bad sums, cut frames
	task automatic send_frame();
		int cls;
		int len;
		int cut;
		logic [7:0] id;
		logic [7:0] err;
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] body[$];
		if (halted || $urandom_range(9) == 0)
			send_item(1'b1, 8'($urandom_range(255)));
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom_range(255)));
		cls = $urandom_range(99);
		id = 8'($urandom_range(255));
		err = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
		cut = 0;
		if (cls < 8) begin
			case ($urandom_range(3))
				0: len = 0;
				1: len = 1;
				2: len = MAX_LEN + 1;
				default: len = $urandom_range(MAX_LEN + 2, 255);
			endcase
			body = {HDR_BYTE, HDR_BYTE, id, 8'(len), err, 8'($urandom_range(255))};
		end else begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(1) ? MAX_LEN : MIN_LEN;
			else if ($urandom_range(3) == 0)
				len = $urandom_range(7, MAX_LEN);
			else
				len = $urandom_range(MIN_LEN, 6);
			body = {HDR_BYTE, HDR_BYTE, id, 8'(len), err};
			sum = id + 8'(len) + err;
			repeat (len - 2) begin
				b = 8'($urandom_range(255));
				body = {body, b};
				sum += b;
			end
			if (cls < 20)
				body = {body, 8'(~sum ^ (8'h01 << $urandom_range(7)))};
			else
				body = {body, 8'(~sum)};
			if (cls >= 20 && cls < 25)
				cut = $urandom_range(2, body.size() - 1);
		end
		foreach (body[i])
			if (cut == 0 || i < cut)
				send_item(1'b0, body[i]);
		if (cut != 0)
			send_item(1'b1, 8'($urandom_range(255)));
	endtask

	// Receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Compare every output transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser < 3)
				kind_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d tdata %0h",
					m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("frame_id", want.id, m_tdata[7:0]);
				check_field("frame_error", want.err, m_tdata[15:8]);
				check_field("error_accum", want.accum, m_tdata[23:16]);
				check_field("raw_word", want.raw, m_tdata[55:24]);
				check_field("position_raw", want.pos, m_tdata[71:56]);
				check_field("speed_signed", want.spd, m_tdata[87:72]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("servo_status_packet_parser regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_phase(0, 0, 0);

		// Directed part
		foreach (stim_rows[i]) begin
			hand_res.kind = stim_rows[i].kind;
			hand_res.id = stim_rows[i].id;
			hand_res.err = stim_rows[i].err;
			hand_res.accum = stim_rows[i].accum;
			hand_res.raw = '0;
			hand_res.pos = '0;
			hand_res.spd = '0;
			hand_res.last = 1'b1;
			send_item(stim_rows[i].act, stim_rows[i].data, stim_rows[i].typed);
		end
		directed_items = items_sent;
		quiesce();

		// Random part: no idling, sender idle, receiver stalls with a long hold, both
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: set_phase(0, 0, 0);
				1: set_phase(60, 0, 0);
				2: set_phase(0, 60, HOLD_CYCLES);
				default: set_phase(27, 27, 0);
			endcase
			while (items_sent < directed_items + (ph + 1) * RANDOM_ITEMS / PHASE_COUNT)
				send_frame();
			quiesce();
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d input transfers (%0d directed), %0d results predicted, %0d seen",
			items_sent, directed_items, predicted, results_seen);
		$display("results by kind: %0d data, %0d status-only, %0d resend requests",
			kind_seen[KIND_DATA], kind_seen[KIND_STATUS], kind_seen[KIND_RESEND]);
		if (errors == 0 && pending_results.size() == 0)
			$display("servo_status_packet_parser regression: pass");
		else
			$display("servo_status_packet_parser regression: fail");
		$finish;
	end

endmodule
